// ----- hdl/tss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_pkg
// Shared constants for the timed step sequencer: table geometry, time width,
// opcodes and configuration register indexes.
// ----------------------------------------------------------------------------
package tss_pkg;

  // table geometry and time width
  localparam int MAX_STEPS = 16;
  localparam int TIME_BITS = 32;
  localparam int STEP_AW   = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int POS_W     = $clog2(MAX_STEPS + 1);
  localparam int ENTRY_W   = TIME_BITS + 1;

  // item opcodes
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_RESET = 3'd3;
  localparam logic [2:0] OP_WRITE = 3'd4;

  // configuration register indexes
  localparam logic REG_NUM_STEPS    = 1'b0;
  localparam logic REG_CYCLE_PERIOD = 1'b1;

endpackage

// ----- hdl/timed_step_sequencer.sv -----
`timescale 1ns / 1ps
// The table read is registered when an item is accepted; the update is then
// computed in the update stage and lands in the output register.
// Throughput: one item per cycle unless the output channel stalls; the next
// item's table read uses the position forwarded from the item being updated.
// Reset clears position, running flag, countdown, registers and pipeline;
// the step table is not cleared.
// ----------------------------------------------------------------------------
// timed_step_sequencer
// Cyclic timed event sequencer: a step table in RAM, a countdown and a step
// position, updated once per tick or command beat.
// ----------------------------------------------------------------------------
module timed_step_sequencer import tss_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic [3:0]  step_slot,
  input  logic [31:0] step_time,
  input  logic        step_action,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        fired,
  output logic [3:0]  fired_step,
  output logic        fired_action,
  output logic        running,
  output logic [4:0]  position,
  output logic        wrapped
);

  // configuration registers
  logic [4:0]  num_steps;
  logic [31:0] cycle_period;

  // sequencer state
  logic [POS_W-1:0]     cur_pos, cur_pos_next;
  logic                 run, run_next;
  logic [TIME_BITS-1:0] delay, delay_next;
  logic [TIME_BITS-1:0] t0;

  // update stage
  logic       s1_valid;
  logic [2:0] s1_op;
  logic       s1_go, out_go, accept;

  // table ram
  logic               ram_we;
  logic [ENTRY_W-1:0] rd_a, rd_b;
  logic [POS_W-1:0]   pos_inc_next;

  // update results
  logic             f_fired, f_act, f_wrap;
  logic [3:0]       f_step;
  logic [POS_W-1:0] cnt;

  // apb port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CYCLE_PERIOD) ? cycle_period : {27'd0, num_steps};

  always_ff @(posedge clk) begin
    if (rst) begin
      num_steps    <= '0;
      cycle_period <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_NUM_STEPS:    num_steps    <= pwdata[4:0];
        REG_CYCLE_PERIOD: cycle_period <= pwdata;
        default:          ;
      endcase
    end
  end

  // handshake
  assign out_go   = !out_valid || out_ready;
  assign s1_go    = s1_valid && out_go;
  assign in_ready = !s1_valid || out_go;
  assign accept   = in_valid && in_ready;

  // table write at accept, first entry shadowed for start and wrap
  assign ram_we = accept && (opcode == OP_WRITE) && (32'(step_slot) < MAX_STEPS);

  always_ff @(posedge clk) begin
    if (ram_we && (step_slot == 4'd0)) begin
      t0 <= TIME_BITS'(step_time);
    end
  end

  // read current and next step using the forwarded position
  assign pos_inc_next = cur_pos_next + POS_W'(1);

  tss_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_STEPS)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (step_slot[STEP_AW-1:0]),
    .wdata   ({step_action, TIME_BITS'(step_time)}),
    .re      (accept),
    .raddr_a (cur_pos_next[STEP_AW-1:0]),
    .raddr_b (pos_inc_next[STEP_AW-1:0]),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op <= opcode;
    end
  end

  // effective step count
  assign cnt = (32'(num_steps) > MAX_STEPS) ? POS_W'(MAX_STEPS) : POS_W'(num_steps);

  // state update
  always_comb begin
    logic [TIME_BITS-1:0] cur_t, nx_t, cyc, gap;
    logic [TIME_BITS:0]   sum;
    logic [POS_W-1:0]     pos_inc;
    cur_t        = rd_a[TIME_BITS-1:0];
    nx_t         = rd_b[TIME_BITS-1:0];
    cyc          = TIME_BITS'(cycle_period);
    pos_inc      = cur_pos + POS_W'(1);
    gap          = (cyc > cur_t) ? (cyc - cur_t) : '0;
    sum          = {1'b0, gap} + {1'b0, t0};
    cur_pos_next = cur_pos;
    run_next     = run;
    delay_next   = delay;
    f_fired      = 1'b0;
    f_step       = 4'd0;
    f_act        = 1'b0;
    f_wrap       = 1'b0;
    if (s1_go) begin
      case (s1_op)
        OP_TICK: begin
          if (run) begin
            if (delay > TIME_BITS'(1)) begin
              delay_next = delay - TIME_BITS'(1);
            end else begin
              delay_next = '0;
              if (cur_pos >= cnt) begin
                run_next = 1'b0;
              end else begin
                f_fired = 1'b1;
                f_step  = 4'(cur_pos);
                f_act   = rd_a[TIME_BITS];
                if (pos_inc < cnt) begin
                  delay_next   = (nx_t >= cur_t) ? (nx_t - cur_t) : '0;
                  cur_pos_next = pos_inc;
                end else if (cycle_period != 32'd0) begin
                  delay_next   = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
                  cur_pos_next = '0;
                  f_wrap       = 1'b1;
                end else begin
                  run_next     = 1'b0;
                  cur_pos_next = '0;
                end
              end
            end
          end
        end
        OP_START: begin
          if (!run) begin
            cur_pos_next = '0;
            if (cnt != '0) begin
              run_next   = 1'b1;
              delay_next = t0;
            end else begin
              delay_next = '0;
            end
          end
        end
        OP_STOP: begin
          run_next   = 1'b0;
          delay_next = '0;
        end
        OP_RESET: begin
          run_next     = 1'b0;
          cur_pos_next = '0;
          delay_next   = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_pos <= '0;
      run     <= 1'b0;
      delay   <= '0;
    end else begin
      cur_pos <= cur_pos_next;
      run     <= run_next;
      delay   <= delay_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_go) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_go) begin
      fired        <= f_fired;
      fired_step   <= f_step;
      fired_action <= f_act;
      running      <= run_next;
      position     <= 5'(cur_pos_next);
      wrapped      <= f_wrap;
    end
  end

  // checks
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    32'(cur_pos) <= MAX_STEPS)
    else $error("step position beyond table");

  a_idle_no_delay: assert property (@(posedge clk) disable iff (rst)
    !run |-> (delay == '0))
    else $error("countdown pending while stopped");

  a_wrap_fires: assert property (@(posedge clk) disable iff (rst)
    (out_valid && wrapped) |-> fired)
    else $error("wrap without a firing");

  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !fired) |-> ((fired_step == 4'd0) && !fired_action))
    else $error("fired fields set without a firing");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid && !out_ready))
    else $error("input stalled without output back pressure");

endmodule

// ----- hdl/tss_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_ram
// Generic RAM with one write port and two registered read ports that share
// a read enable; read data holds while the enable is low.
// ----------------------------------------------------------------------------
module tss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                          rdata_a,
  output logic [WIDTH-1:0]                          rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read ports
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ----- test/timed_step_sequencer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_step_sequencer_tb
// Drives command beats (ticks, start, stop, reset, step table writes) into the
// timed step sequencer under several step count and cycle period settings and
// with random gaps on both channels. Every accepted command is run through a
// behavioral copy of the sequencer, and each result beat is checked field by
// field against the oldest predicted report.
// ----------------------------------------------------------------------------
module timed_step_sequencer_tb;
  import tss_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  slot;
    logic [31:0] t;
    logic        act;
  } seq_cmd_t;

  typedef struct packed {
    logic       fired;
    logic [3:0] step;
    logic       action;
    logic       running;
    logic [4:0] pos;
    logic       wrapped;
  } fire_report_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // configuration port
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  // command channel
  logic        in_valid    = 1'b0;
  logic        in_ready;
  logic [2:0]  opcode      = OP_TICK;
  logic [3:0]  step_slot   = '0;
  logic [31:0] step_time   = '0;
  logic        step_action = 1'b0;

  // report channel
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        fired;
  logic [3:0]  fired_step;
  logic        fired_action;
  logic        running;
  logic [4:0]  position;
  logic        wrapped;

  // stimulus and scoreboard
  seq_cmd_t     pending_cmds[$];
  fire_report_t expected_reports[$];
  int unsigned  send_idle_pct  = 0;
  int unsigned  recv_stall_pct = 0;
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count    = 0;

  // predicted sequencer state
  logic [31:0] tab_time[MAX_STEPS];
  logic        tab_action[MAX_STEPS];
  logic [4:0]  seq_pos    = '0;
  logic        seq_run    = 1'b0;
  logic [31:0] seq_wait   = '0;
  logic [4:0]  cfg_steps  = '0;
  logic [31:0] cfg_period = '0;

  timed_step_sequencer u_top (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .step_slot    (step_slot),
    .step_time    (step_time),
    .step_action  (step_action),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .fired        (fired),
    .fired_step   (fired_step),
    .fired_action (fired_action),
    .running      (running),
    .position     (position),
    .wrapped      (wrapped)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // apply one command to the predicted state and return its report
  function automatic fire_report_t advance_sequencer(input logic [2:0] op,
                                                     input logic [3:0] slot,
                                                     input logic [31:0] tval,
                                                     input logic act);
    fire_report_t rep;
    logic [4:0]   cnt;
    logic [4:0]   nxt;
    logic [31:0]  cur;
    logic [31:0]  gap;
    logic [32:0]  sum;
    rep = '0;
    cnt = (cfg_steps > 5'(MAX_STEPS)) ? 5'(MAX_STEPS) : cfg_steps;
    case (op)
      OP_TICK: begin
        if (seq_run) begin
          if (seq_wait > 32'd1) begin
            seq_wait = seq_wait - 32'd1;
          end else begin
            seq_wait = '0;
            if (seq_pos >= cnt) begin
              // count lowered under a running timeline
              seq_run = 1'b0;
            end else begin
              cur        = tab_time[seq_pos[3:0]];
              rep.fired  = 1'b1;
              rep.step   = seq_pos[3:0];
              rep.action = tab_action[seq_pos[3:0]];
              nxt        = seq_pos + 5'd1;
              if (nxt < cnt) begin
                // gap to next step, zero when times go backward
                seq_wait = (tab_time[nxt[3:0]] >= cur) ? tab_time[nxt[3:0]] - cur : '0;
                seq_pos  = nxt;
              end else if (cfg_period != 32'd0) begin
                // wrap: rest of the cycle plus first step time, saturating
                gap         = (cfg_period > cur) ? cfg_period - cur : '0;
                sum         = {1'b0, gap} + {1'b0, tab_time[0]};
                seq_wait    = sum[32] ? '1 : sum[31:0];
                seq_pos     = '0;
                rep.wrapped = 1'b1;
              end else begin
                seq_run = 1'b0;
                seq_pos = '0;
              end
            end
          end
        end
      end
      OP_START: begin
        if (!seq_run) begin
          seq_pos = '0;
          if (cnt != '0) begin
            seq_run  = 1'b1;
            seq_wait = tab_time[0];
          end else begin
            seq_wait = '0;
          end
        end
      end
      OP_STOP: begin
        seq_run  = 1'b0;
        seq_wait = '0;
      end
      OP_RESET: begin
        seq_run  = 1'b0;
        seq_pos  = '0;
        seq_wait = '0;
      end
      OP_WRITE: begin
        tab_time[slot]   = tval;
        tab_action[slot] = act;
      end
      default: ;
    endcase
    rep.running = seq_run;
    rep.pos     = seq_pos;
    return rep;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (mismatch_count < 100)
      $display("mismatch at cycle %0d: %s got %0h expected %0h",
               cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // command driver: predicts each accepted beat
  always @(posedge clk) begin : drive_cmds
    seq_cmd_t nxt_cmd;
    logic     load;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        expected_reports.push_back(advance_sequencer(opcode, step_slot, step_time,
                                                     step_action));
      if (!in_valid || in_ready) begin
        load = (pending_cmds.size() != 0) && ($urandom_range(0, 99) >= send_idle_pct);
        if (load) begin
          nxt_cmd     = pending_cmds.pop_front();
          opcode      <= nxt_cmd.op;
          step_slot   <= nxt_cmd.slot;
          step_time   <= nxt_cmd.t;
          step_action <= nxt_cmd.act;
        end
        in_valid <= load;
      end
    end
  end

  // report monitor
  always @(posedge clk) begin : watch_reports
    fire_report_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          note_mismatch("unexpected report beat", '0, '0);
        end else begin
          want = expected_reports.pop_front();
          if (fired !== want.fired)
            note_mismatch("fired", 32'(fired), 32'(want.fired));
          if (fired_step !== want.step)
            note_mismatch("fired_step", 32'(fired_step), 32'(want.step));
          if (fired_action !== want.action)
            note_mismatch("fired_action", 32'(fired_action), 32'(want.action));
          if (running !== want.running)
            note_mismatch("running", 32'(running), 32'(want.running));
          if (position !== want.pos)
            note_mismatch("position", 32'(position), 32'(want.pos));
          if (wrapped !== want.wrapped)
            note_mismatch("wrapped", 32'(wrapped), 32'(want.wrapped));
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  function automatic void push_cmd(input logic [2:0] op, input logic [3:0] slot,
                                   input logic [31:0] t, input logic act);
    seq_cmd_t c;
    c.op   = op;
    c.slot = slot;
    c.t    = t;
    c.act  = act;
    pending_cmds.push_back(c);
  endfunction

  // mostly short step times so that steps fire often, now and then any value
  function automatic logic [31:0] pick_time();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 8);
    if (r < 95) return $urandom_range(0, 40);
    return $urandom;
  endfunction

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == {REG_NUM_STEPS, 2'b00}) cfg_steps = data[4:0];
    else if (addr == {REG_CYCLE_PERIOD, 2'b00}) cfg_period = data;
  endtask

  task automatic write_config(input logic [4:0] steps, input logic [31:0] period);
    write_reg({REG_NUM_STEPS, 2'b00}, {27'd0, steps});
    write_reg({REG_CYCLE_PERIOD, 2'b00}, period);
  endtask

  // wait until every command is accepted and every report checked
  task automatic drain();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || in_valid || expected_reports.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // mostly well-formed runs (stop or reset, table writes, start, ticks),
  // the rest single random commands
  task automatic queue_random(input int n);
    int          queued;
    int          k;
    int          ticks;
    logic [2:0]  op;
    queued = 0;
    while (queued < n) begin
      if ($urandom_range(0, 99) < 75) begin
        push_cmd($urandom_range(0, 1) ? OP_STOP : OP_RESET, 4'($urandom_range(0, 15)),
                 $urandom, 1'($urandom_range(0, 1)));
        k = $urandom_range(0, 3);
        repeat (k) push_cmd(OP_WRITE, 4'($urandom_range(0, 15)), pick_time(),
                            1'($urandom_range(0, 1)));
        push_cmd(OP_START, 4'($urandom_range(0, 15)), $urandom,
                 1'($urandom_range(0, 1)));
        ticks = $urandom_range(4, 40);
        repeat (ticks) begin
          if ($urandom_range(0, 99) < 5)
            push_cmd(OP_WRITE, 4'($urandom_range(0, 15)), pick_time(),
                     1'($urandom_range(0, 1)));
          else
            push_cmd(OP_TICK, 4'($urandom_range(0, 15)), $urandom,
                     1'($urandom_range(0, 1)));
        end
        queued += 2 + k + ticks;
      end else begin
        op = 3'($urandom_range(0, 7));
        push_cmd(op, 4'($urandom_range(0, 15)),
                 (op == OP_WRITE) ? pick_time() : $urandom, 1'($urandom_range(0, 1)));
        if (op <= OP_WRITE) queued++;
      end
    end
  endtask

  task automatic run_phase(input logic [4:0] steps, input logic [31:0] period,
                           input int unsigned send_pct, input int unsigned stall_pct,
                           input int n);
    write_config(steps, period);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    queue_random(n);
    drain();
  endtask

  // main sequence
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    write_config(5'd4, 32'd0);

    // directed: table extremes, unused opcodes, run-once timeline with
    // backward and equal step times, start while running, stop, reset
    push_cmd(OP_WRITE, 4'd0, 32'd2, 1'b1);
    push_cmd(OP_WRITE, 4'd1, 32'd5, 1'b0);
    push_cmd(OP_WRITE, 4'd2, 32'd3, 1'b1);
    push_cmd(OP_WRITE, 4'd3, 32'd3, 1'b0);
    push_cmd(OP_WRITE, 4'd4, 32'hFFFF_FFFF, 1'b1);
    push_cmd(OP_WRITE, 4'd5, 32'd0, 1'b0);
    push_cmd(3'd5, 4'd15, 32'hFFFF_FFFF, 1'b1);
    push_cmd(3'd6, 4'd0, 32'd0, 1'b0);
    push_cmd(3'd7, 4'd9, 32'h5A5A_A5A5, 1'b1);
    push_cmd(OP_TICK, 4'd0, 32'd0, 1'b0);
    push_cmd(OP_START, 4'd0, 32'd0, 1'b0);
    push_cmd(OP_START, 4'd0, 32'd0, 1'b0);
    repeat (7) push_cmd(OP_TICK, 4'd0, 32'd0, 1'b0);
    push_cmd(OP_STOP, 4'd0, 32'd0, 1'b0);
    push_cmd(OP_START, 4'd0, 32'd0, 1'b0);
    push_cmd(OP_RESET, 4'd0, 32'd0, 1'b0);

    // fill the rest of the table before any larger step count is used
    for (int i = 6; i < MAX_STEPS; i++)
      push_cmd(OP_WRITE, 4'(i), pick_time(), 1'($urandom_range(0, 1)));
    queue_random(150);
    drain();

    // step count, cycle period, sender idle, receiver stall, beats
    run_phase(5'd16, 32'd30, 0, 0, 200);
    run_phase(5'd1, 32'd1, 49, 0, 200);
    run_phase(5'd31, 32'd25, 0, 49, 200);
    run_phase(5'd0, 32'd10, 10, 10, 150);
    run_phase(5'd7, 32'hFFFF_FFFF, 49, 0, 200);
    run_phase(5'd3, 32'd12, 0, 49, 200);
    run_phase(5'd17, 32'd0, 10, 10, 200);
    run_phase(5'($urandom_range(1, 16)), 32'($urandom_range(0, 50)), 0, 0, 200);

    if (mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
